// File: rtl/core/lsic_pkg.sv
// Shared types and constants for the light switch input controller.
`timescale 1ns / 1ps
`default_nettype none

package lsic_pkg;

  // Command codes carried in s_tuser.
  typedef enum logic [2:0] {
    CMD_SAMPLE = 3'd0,
    CMD_ON     = 3'd1,
    CMD_OFF    = 3'd2,
    CMD_TOGGLE = 3'd3,
    CMD_RESET  = 3'd4,
    CMD_READ   = 3'd5
  } cmd_t;

  // Device kinds.
  localparam logic [1:0] KIND_ONOFF   = 2'd0;
  localparam logic [1:0] KIND_TIMED   = 2'd1;
  localparam logic [1:0] KIND_HEATER  = 2'd2;
  localparam logic [1:0] KIND_COUNTER = 2'd3;

  // Input modes.
  localparam logic [2:0] MODE_PRESS_RELEASE = 3'd0;
  localparam logic [2:0] MODE_PRESS_HOLD    = 3'd1;
  localparam logic [2:0] MODE_COUNT_UP      = 3'd2;
  localparam logic [2:0] MODE_HEAT_ON       = 3'd3;
  localparam logic [2:0] MODE_HEAT_OFF      = 3'd4;

  // Press event codes.
  localparam logic [2:0] EV_NONE              = 3'd0;
  localparam logic [2:0] EV_MOMENTARY         = 3'd1;
  localparam logic [2:0] EV_LONG              = 3'd2;
  localparam logic [2:0] EV_CENTRAL_MOMENTARY = 3'd3;
  localparam logic [2:0] EV_CENTRAL_LONG      = 3'd4;
  localparam logic [2:0] EV_REPORT            = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] REG_DEVICE_KIND    = 3'd0;
  localparam logic [2:0] REG_INPUT_MODE     = 3'd1;
  localparam logic [2:0] REG_ON_TIMEOUT_MS  = 3'd2;
  localparam logic [2:0] REG_LONG_PRESS_MS  = 3'd3;
  localparam logic [2:0] REG_SETTLE_MS      = 3'd4;
  localparam logic [2:0] REG_CENTRAL_BUTTON = 3'd5;
  localparam logic [2:0] REG_LEVEL_OFF      = 3'd6;
  localparam logic [2:0] REG_LEVEL_ON       = 3'd7;

  // Reset values of the timing registers.
  localparam logic [31:0] ON_TIMEOUT_RESET = 32'd60000;
  localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;
  localparam logic [15:0] SETTLE_RESET     = 16'd100;

  // One result item, lowest field last.
  typedef struct packed {
    logic [31:0] count_value;
    logic        turned_off;
    logic        turned_on;
    logic        is_on;
    logic [7:0]  drive_level;
    logic [2:0]  press_event;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/light_switch_input_controller.sv
// Top level of the light switch input controller for one output channel.
`timescale 1ns / 1ps
`default_nettype none

// One channel of a switch controller. Each input item holds a command (s_tuser) plus the
// sampled button level and a millisecond tick (s_tdata); each item gives exactly one result
// item with the press event, the drive level, on/off status, change pulses and, for a counter
// read, the counter value before clearing. The block takes one item per clock cycle and
// returns its result in the next cycle: the whole state update (timer tick, timer checks,
// press classification and command) is one pass of logic between the state registers and the
// result register. The input stalls only while the result register holds an item that the
// downstream side has not yet taken. Configuration is written through cfg_we / cfg_index /
// cfg_data and takes effect at once; write it only while no item is in flight. Writing the
// pulse counter kind to device_kind restarts the on timer.
module light_switch_input_controller (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [0] button_level, [1] ms_tick, rest zero
  input  wire logic [2:0]  s_tuser,   // [2:0] command
  // Result stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [2:0] press_event, [10:3] drive_level, [11] is_on, [12] turned_on,
  // [13] turned_off, [45:14] count_value, rest zero
  output logic [47:0]      m_tdata
);
  import lsic_pkg::*;

  // Configuration registers.
  logic [1:0]  device_kind;
  logic [2:0]  input_mode;
  logic [31:0] on_timeout_ms;
  logic [15:0] long_press_ms;
  logic [15:0] settle_ms;
  logic        central_button;
  logic [7:0]  level_off;
  logic [7:0]  level_on;

  // Channel state.
  logic        output_on, output_on_next;
  logic        last_level, last_level_next;
  logic        press_active, press_active_next;
  logic [15:0] hold_elapsed, hold_elapsed_next;
  logic        hold_done, hold_done_next;
  logic [15:0] settle_elapsed, settle_elapsed_next;
  logic        settle_done, settle_done_next;
  logic [31:0] on_elapsed, on_elapsed_next;
  logic        on_done, on_done_next;
  logic [31:0] pulse_count, pulse_count_next;

  result_t     result, result_next;
  logic        accept;
  logic        level;
  logic        tick;
  cmd_t        command;

  // The result register frees up either when empty or when its item leaves this cycle.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign level    = s_tdata[0];
  assign tick     = s_tdata[1];
  assign command  = cmd_t'(s_tuser);
  assign m_tdata  = {2'b00, result};

  always_comb begin
    logic        change;
    logic        on_check;
    logic        heater_forced;
    logic [2:0]  event_code;
    logic [31:0] count;

    output_on_next      = output_on;
    last_level_next     = last_level;
    press_active_next   = press_active;
    hold_done_next      = hold_done;
    settle_done_next    = settle_done;
    on_done_next        = on_done;
    pulse_count_next    = pulse_count;
    change              = 1'b0;
    event_code          = EV_NONE;
    count               = '0;
    heater_forced       = (device_kind == KIND_HEATER) && (input_mode == MODE_HEAT_ON);

    // Timers advance on a tick while running and stop at full scale.
    hold_elapsed_next   = hold_elapsed
                        + {15'd0, tick && !hold_done && (hold_elapsed != 16'hFFFF)};
    settle_elapsed_next = settle_elapsed
                        + {15'd0, tick && !settle_done && (settle_elapsed != 16'hFFFF)};
    on_elapsed_next     = on_elapsed
                        + {31'd0, tick && !on_done && (on_elapsed != 32'hFFFF_FFFF)};

    on_check = !on_done && (on_elapsed_next > on_timeout_ms);

    unique case (command)
      CMD_SAMPLE: begin
        if (on_check) begin
          on_done_next = 1'b1;
        end
        if (on_check && device_kind == KIND_COUNTER) begin
          // Periodic counter report; the button is not looked at this time.
          on_elapsed_next = '0;
          on_done_next    = 1'b0;
          event_code      = EV_REPORT;
        end else begin
          if (on_check && device_kind == KIND_TIMED) begin
            output_on_next = 1'b0;
            change         = 1'b1;
          end
          if (input_mode == MODE_PRESS_RELEASE) begin
            last_level_next = level;
            if (level) begin
              if (!press_active) begin
                hold_elapsed_next = '0;
                hold_done_next    = 1'b0;
              end
              press_active_next = 1'b1;
            end else if (press_active) begin
              press_active_next = 1'b0;
              if (!hold_done && (hold_elapsed_next > long_press_ms)) begin
                hold_done_next = 1'b1;
                event_code     = central_button ? EV_CENTRAL_LONG : EV_LONG;
              end else begin
                event_code     = central_button ? EV_CENTRAL_MOMENTARY : EV_MOMENTARY;
              end
            end
          end else if (input_mode == MODE_PRESS_HOLD || input_mode == MODE_HEAT_OFF) begin
            if ((last_level != level) && !press_active) begin
              last_level_next     = level;
              press_active_next   = 1'b1;
              settle_elapsed_next = '0;
              settle_done_next    = 1'b0;
            end else if (!settle_done && (settle_elapsed_next > settle_ms)) begin
              settle_done_next  = 1'b1;
              press_active_next = 1'b0;
              event_code        = EV_MOMENTARY;
            end
          end else if (input_mode == MODE_COUNT_UP) begin
            last_level_next = level;
            if (level) begin
              press_active_next = 1'b1;
            end else if (press_active) begin
              // A full counter keeps the press pending and reports until it is read.
              if (pulse_count == 32'hFFFF_FFFF) begin
                event_code = EV_REPORT;
              end else begin
                pulse_count_next  = pulse_count + 32'd1;
                press_active_next = 1'b0;
              end
            end
          end
        end
      end
      CMD_ON: begin
        if (device_kind == KIND_ONOFF || device_kind == KIND_TIMED || heater_forced) begin
          output_on_next = 1'b1;
          change         = 1'b1;
        end
        if (device_kind == KIND_TIMED) begin
          on_elapsed_next = '0;
          on_done_next    = 1'b0;
        end
      end
      CMD_OFF: begin
        if (device_kind == KIND_ONOFF || device_kind == KIND_TIMED || heater_forced) begin
          output_on_next = 1'b0;
          change         = 1'b1;
        end
      end
      CMD_TOGGLE: begin
        if (device_kind == KIND_HEATER) begin
          // The heater simply follows the input level.
          output_on_next = level;
        end else if (device_kind != KIND_COUNTER) begin
          output_on_next = !output_on;
          change         = 1'b1;
          if (!output_on && device_kind == KIND_TIMED) begin
            on_elapsed_next = '0;
            on_done_next    = 1'b0;
          end
        end
      end
      CMD_RESET: begin
        output_on_next = 1'b0;
        change         = 1'b0;
      end
      CMD_READ: begin
        count            = pulse_count;
        pulse_count_next = '0;
      end
      default: begin
      end
    endcase

    result_next.press_event = event_code;
    result_next.drive_level = output_on_next ? level_on : level_off;
    result_next.is_on       = output_on_next;
    result_next.turned_on   = change && output_on_next;
    result_next.turned_off  = change && !output_on_next;
    result_next.count_value = count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_kind    <= KIND_ONOFF;
      input_mode     <= MODE_PRESS_RELEASE;
      on_timeout_ms  <= ON_TIMEOUT_RESET;
      long_press_ms  <= LONG_PRESS_RESET;
      settle_ms      <= SETTLE_RESET;
      central_button <= 1'b0;
      level_off      <= 8'd0;
      level_on       <= 8'd255;
      output_on      <= 1'b0;
      last_level     <= 1'b0;
      press_active   <= 1'b0;
      hold_elapsed   <= '0;
      hold_done      <= 1'b1;
      settle_elapsed <= '0;
      settle_done    <= 1'b1;
      on_elapsed     <= '0;
      on_done        <= 1'b1;
      pulse_count    <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (accept) begin
        output_on      <= output_on_next;
        last_level     <= last_level_next;
        press_active   <= press_active_next;
        hold_elapsed   <= hold_elapsed_next;
        hold_done      <= hold_done_next;
        settle_elapsed <= settle_elapsed_next;
        settle_done    <= settle_done_next;
        on_elapsed     <= on_elapsed_next;
        on_done        <= on_done_next;
        pulse_count    <= pulse_count_next;
        m_tvalid       <= 1'b1;
      end else if (m_tready) begin
        m_tvalid       <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DEVICE_KIND: begin
            device_kind <= cfg_data[1:0];
            if (cfg_data[1:0] == KIND_COUNTER) begin
              on_elapsed <= '0;
              on_done    <= 1'b0;
            end
          end
          REG_INPUT_MODE:     input_mode     <= cfg_data[2:0];
          REG_ON_TIMEOUT_MS:  on_timeout_ms  <= cfg_data;
          REG_LONG_PRESS_MS:  long_press_ms  <= cfg_data[15:0];
          REG_SETTLE_MS:      settle_ms      <= cfg_data[15:0];
          REG_CENTRAL_BUTTON: central_button <= cfg_data[0];
          REG_LEVEL_OFF:      level_off      <= cfg_data[7:0];
          REG_LEVEL_ON:       level_on       <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  // A result never reports both a change to on and a change to off.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(result.turned_on && result.turned_off))
    else $error("result marks both turned_on and turned_off");

  // Every accepted item leaves a result in the output register next cycle.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted item produced no result");

  // The pulse counter only steps by one or clears on a read, and only for an accepted item.
  assert property (@(posedge clk) disable iff (rst)
    !$stable(pulse_count) |-> $past(accept) &&
      ((pulse_count == $past(pulse_count) + 32'd1) || (pulse_count == 32'd0)))
    else $error("pulse counter changed unexpectedly");

  // Press events stay within the defined codes.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (result.press_event <= EV_REPORT))
    else $error("undefined press event code");

endmodule

`default_nettype wire
